FILE: hdl/coab_pkg.sv
package coab_pkg;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_CURSOR_LEFT   = 3'd0,
    CFG_CURSOR_TOP    = 3'd1,
    CFG_CURSOR_WIDTH  = 3'd2,
    CFG_CURSOR_HEIGHT = 3'd3,
    CFG_REGION_WIDTH  = 3'd4,
    CFG_REGION_HEIGHT = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Input item operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic        op;
    logic [11:0] cursor_index;
    logic [31:0] cursor_argb;
    logic [23:0] raw_pixel;
    logic [11:0] pix_x;
    logic [11:0] pix_y;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_of_region;
  } out_t;

endpackage

FILE: hdl/cursor_overlay_alpha_blend_unit.sv
// Cursor overlay alpha blender. Load transfers (op = 0) write one ARGB word
// into the cursor image memory (entry = row * MAX_CURSOR_SIDE + column) and
// give no result; pixel transfers (op = 1) give exactly one result. A pixel
// inside the region and the cursor rectangle is blended per channel as
// (c*a + bg*(255-a))/255; any other pixel passes through, alpha is always
// 255 and out_of_region flags pixels past the region size. One transfer is
// taken every cycle while the pipe advances; a pixel's result goes through
// memory read, multiply and divide-by-255 into the output register. The whole
// pipe advances whenever the output register is empty or being taken, so
// in_ready drops only while a result sits in the output register and
// out_ready is low. The cursor memory has one write and one read port and no
// clearing pass: an entry must be loaded before a pixel reads it. Size
// registers above the parameter limits saturate to them. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module cursor_overlay_alpha_blend_unit #(
  parameter int MAX_CURSOR_SIDE = 64,
  parameter int MAX_REGION_SIDE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  coab_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output coab_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [coab_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [coab_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import coab_pkg::*;

  localparam int STORE_DEPTH = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE;
  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SCW = (MAX_CURSOR_SIDE > 1) ? $clog2(MAX_CURSOR_SIDE) : 1;
  // Comparison width: covers 4096 + 8192 coordinates and all size limits
  localparam int CW  = 16;

  // Configuration registers
  logic signed [13:0] cur_left_r;
  logic signed [13:0] cur_top_r;
  logic [6:0]         cur_width_r;
  logic [6:0]         cur_height_r;
  logic [12:0]        reg_width_r;
  logic [12:0]        reg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_left_r   <= '0;
      cur_top_r    <= '0;
      cur_width_r  <= '0;
      cur_height_r <= '0;
      reg_width_r  <= 13'd4096;
      reg_height_r <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CURSOR_LEFT:   cur_left_r   <= $signed(cfg_wdata);
        CFG_CURSOR_TOP:    cur_top_r    <= $signed(cfg_wdata);
        CFG_CURSOR_WIDTH:  cur_width_r  <= cfg_wdata[6:0];
        CFG_CURSOR_HEIGHT: cur_height_r <= cfg_wdata[6:0];
        CFG_REGION_WIDTH:  reg_width_r  <= cfg_wdata[12:0];
        CFG_REGION_HEIGHT: reg_height_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Saturated sizes
  logic [CW-1:0] rw_cap, rh_cap, cw_cap, ch_cap;
  always_comb begin
    rw_cap = (CW'(reg_width_r) > CW'(MAX_REGION_SIDE)) ? CW'(MAX_REGION_SIDE)
                                                       : CW'(reg_width_r);
    rh_cap = (CW'(reg_height_r) > CW'(MAX_REGION_SIDE)) ? CW'(MAX_REGION_SIDE)
                                                        : CW'(reg_height_r);
    cw_cap = (CW'(cur_width_r) > CW'(MAX_CURSOR_SIDE)) ? CW'(MAX_CURSOR_SIDE)
                                                       : CW'(cur_width_r);
    ch_cap = (CW'(cur_height_r) > CW'(MAX_CURSOR_SIDE)) ? CW'(MAX_CURSOR_SIDE)
                                                        : CW'(cur_height_r);
  end

  // Pipe advance: everything moves when the output register can take data
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Stage 0: region and cursor hit tests, memory address
  logic               outside0, hit0;
  logic signed [CW-1:0] cx, cy;
  logic [AW-1:0]      rd_addr;

  always_comb begin
    outside0 = (CW'(in_data.pix_x) >= rw_cap) || (CW'(in_data.pix_y) >= rh_cap);
    cx = $signed({{(CW-12){1'b0}}, in_data.pix_x}) - CW'(cur_left_r);
    cy = $signed({{(CW-12){1'b0}}, in_data.pix_y}) - CW'(cur_top_r);
    hit0 = !outside0 && !cx[CW-1] && !cy[CW-1] &&
           ($unsigned(cx) < cw_cap) && ($unsigned(cy) < ch_cap);
    rd_addr = AW'(AW'(cy[SCW-1:0]) * AW'(MAX_CURSOR_SIDE)) + AW'(cx[SCW-1:0]);
  end

  // Cursor image memory: load writes at transfer, pixel reads are registered
  logic [31:0] cursor_mem [STORE_DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_xfer && (in_data.op == OP_LOAD) &&
        (32'(in_data.cursor_index) < 32'(STORE_DEPTH))) begin
      cursor_mem[AW'(in_data.cursor_index)] <= in_data.cursor_argb;
    end
    if (adv) begin
      rd_data_r <= cursor_mem[rd_addr];
    end
  end

  // Stage 1 registers
  logic        v1_r;
  logic [23:0] bg1_r;
  logic        out1_r;
  logic        hit1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_xfer && (in_data.op == OP_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bg1_r  <= in_data.raw_pixel;
      out1_r <= outside0;
      hit1_r <= hit0;
    end
  end

  // Stage 1 -> 2: products. A miss blends with alpha 0, giving bg*255.
  logic [7:0]  a_eff;
  logic [7:0]  c_eff [3];
  logic [7:0]  bg1 [3];
  logic [15:0] sum1 [3];

  always_comb begin
    a_eff = hit1_r ? rd_data_r[31:24] : 8'd0;
    bg1[0] = bg1_r[23:16];
    bg1[1] = bg1_r[15:8];
    bg1[2] = bg1_r[7:0];
    c_eff[0] = hit1_r ? rd_data_r[23:16] : 8'd0;
    c_eff[1] = hit1_r ? rd_data_r[15:8]  : 8'd0;
    c_eff[2] = hit1_r ? rd_data_r[7:0]   : 8'd0;
    for (int i = 0; i < 3; i++) begin
      sum1[i] = (16'(c_eff[i]) * 16'(a_eff)) +
                (16'(bg1[i]) * 16'(8'd255 - a_eff));
    end
  end

  // Stage 2 registers
  logic        v2_r;
  logic [15:0] sum2_r [3];
  logic        out2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum2_r <= sum1;
      out2_r <= out1_r;
    end
  end

  // Exact x/255 for x <= 65534: (x + 1 + (x >> 8)) >> 8
  logic [7:0] quo [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = 8'((17'(sum2_r[i]) + 17'd1 + 17'(sum2_r[i][15:8])) >> 8);
    end
  end

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_red       <= quo[0];
      out_data_r.out_green     <= quo[1];
      out_data_r.out_blue      <= quo[2];
      out_data_r.out_alpha     <= ALPHA_OPAQUE;
      out_data_r.out_of_region <= out2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/coab_checker.sv
module coab_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input coab_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input coab_pkg::out_t out_data
);
  import coab_pkg::*;

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Backpressure only from a held result
  a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  // Pixel result arrives through the pipe while the output side stays free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.op == OP_PIXEL) ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("pixel result missing");

  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_alpha == ALPHA_OPAQUE)
    else $error("alpha not opaque");

endmodule

bind cursor_overlay_alpha_blend_unit coab_checker u_coab_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import coab_pkg::*;

  localparam int MAX_CURSOR_SIDE = 64;
  localparam int MAX_REGION_SIDE = 4096;
  localparam int STORE_DEPTH     = MAX_CURSOR_SIDE * MAX_CURSOR_SIDE;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);
  localparam int FULL_ALPHA      = 255;
  localparam int COORD_MAX       = 4095;

  // Addresses past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 10;    // pipe is 3 deep, loads give no result
  localparam int HOLD_CYCLES   = 300;   // long output stall for the pressure test
  localparam int QUIET_LIMIT   = 4000;  // watchdog: cycles without any transfer
  localparam int MAX_PRINTS    = 50;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cursor_overlay_alpha_blend_unit #(
    .MAX_CURSOR_SIDE (MAX_CURSOR_SIDE),
    .MAX_REGION_SIDE (MAX_REGION_SIDE)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register values as written, cursor image as loaded,
  // and the queue of blended pixels still owed by the DUT.
  // ---------------------------------------------------------------------------
  int          cur_left = 0;
  int          cur_top  = 0;
  int unsigned cur_w    = 0;
  int unsigned cur_h    = 0;
  int unsigned reg_w    = 4096;
  int unsigned reg_h    = 4096;

  logic [31:0] cursor_words [STORE_DEPTH];
  bit          word_loaded  [STORE_DEPTH];
  out_t        expected_px  [$];

  // Test control shared with the result sink.
  bit idle_on   = 1'b1;  // random gaps on both sides
  bit hold_req  = 1'b0;  // ask the sink for one long stall
  int hold_left = 0;

  int err_count   = 0;
  int n_pixels    = 0;
  int n_loads     = 0;
  int n_writes    = 0;
  int n_checked   = 0;
  int quiet_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void mirror_write(input logic [CFG_IDX_W-1:0] addr,
                                       input logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_CURSOR_LEFT:   cur_left = int'($signed(data));
      CFG_CURSOR_TOP:    cur_top  = int'($signed(data));
      CFG_CURSOR_WIDTH:  cur_w    = 32'(data[6:0]);
      CFG_CURSOR_HEIGHT: cur_h    = 32'(data[6:0]);
      CFG_REGION_WIDTH:  reg_w    = 32'(data[12:0]);
      CFG_REGION_HEIGHT: reg_h    = 32'(data[12:0]);
      default: ;  // spare index: ignored
    endcase
  endfunction

  // Region size saturates at the limit; a size of zero puts every pixel outside.
  function automatic bit outside_region(input in_t it);
    int unsigned w_eff;
    int unsigned h_eff;
    w_eff = (reg_w > MAX_REGION_SIDE) ? MAX_REGION_SIDE : reg_w;
    h_eff = (reg_h > MAX_REGION_SIDE) ? MAX_REGION_SIDE : reg_h;
    return (32'(it.pix_x) >= w_eff) || (32'(it.pix_y) >= h_eff);
  endfunction

  // Cursor image entry that a pixel blends with, or -1 when it is not blended.
  function automatic int cursor_entry(input in_t it);
    int cx;
    int cy;
    int cw_eff;
    int ch_eff;
    cw_eff = (cur_w > MAX_CURSOR_SIDE) ? MAX_CURSOR_SIDE : int'(cur_w);
    ch_eff = (cur_h > MAX_CURSOR_SIDE) ? MAX_CURSOR_SIDE : int'(cur_h);
    if (outside_region(it))
      return -1;
    cx = int'(it.pix_x) - cur_left;
    cy = int'(it.pix_y) - cur_top;
    if (cx >= 0 && cx < cw_eff && cy >= 0 && cy < ch_eff)
      return cy * MAX_CURSOR_SIDE + cx;
    return -1;
  endfunction

  function automatic logic [7:0] mix_channel(input int unsigned c, input int unsigned bg,
                                             input int unsigned a);
    return 8'((c * a + bg * (FULL_ALPHA - a)) / FULL_ALPHA);
  endfunction

  function automatic out_t blend_result(input in_t it);
    out_t        res;
    int          slot;
    logic [31:0] word;
    res.out_red       = it.raw_pixel[23:16];
    res.out_green     = it.raw_pixel[15:8];
    res.out_blue      = it.raw_pixel[7:0];
    res.out_alpha     = ALPHA_OPAQUE;
    res.out_of_region = outside_region(it);
    slot = cursor_entry(it);
    if (slot >= 0) begin
      word = cursor_words[STORE_AW'(slot)];
      res.out_red   = mix_channel(32'(word[23:16]), 32'(res.out_red), 32'(word[31:24]));
      res.out_green = mix_channel(32'(word[15:8]), 32'(res.out_green), 32'(word[31:24]));
      res.out_blue  = mix_channel(32'(word[7:0]), 32'(res.out_blue), 32'(word[31:24]));
    end
    return res;
  endfunction

  // Cursor words lean toward fully clear and fully opaque alpha.
  function automatic logic [31:0] rand_argb();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 3))
      0: w[31:24] = 8'h00;
      1: w[31:24] = 8'hFF;
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. valid is never dropped and raised in the same step: a transfer
  // either follows directly (valid stays high) or after a gap, and any path
  // that stops sending lowers valid itself.
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_t it);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge: update the shadow in arrival order
    if (it.op == OP_PIXEL) begin
      expected_px.push_back(blend_result(it));
      n_pixels++;
    end else begin
      cursor_words[it.cursor_index] = it.cursor_argb;
      word_loaded[it.cursor_index]  = 1'b1;
      n_loads++;
    end
  endtask

  task automatic send_load(input int idx, input logic [31:0] argb);
    in_t it;
    it              = in_t'({$urandom, $urandom, $urandom});  // unused fields random
    it.op           = OP_LOAD;
    it.cursor_index = 12'(idx);
    it.cursor_argb  = argb;
    send_item(it);
  endtask

  // A pixel that would read a never-loaded entry gets that entry loaded first.
  task automatic send_pixel(input logic [23:0] raw, input int x, input int y);
    in_t it;
    int  slot;
    it           = in_t'({$urandom, $urandom, $urandom});
    it.op        = OP_PIXEL;
    it.raw_pixel = raw;
    it.pix_x     = 12'(x);
    it.pix_y     = 12'(y);
    slot = cursor_entry(it);
    if (slot >= 0 && !word_loaded[STORE_AW'(slot)])
      send_load(slot, rand_argb());
    send_item(it);
  endtask

  // Stop sending, wait for every owed result, then let trailing loads settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers, then one spare address, while the block is idle.
  task automatic configure(input int left, input int top, input int cw, input int ch,
                           input int rw, input int rh);
    logic [CFG_IDX_W-1:0]  addr_list [7];
    logic [CFG_DATA_W-1:0] data_list [7];
    int k;
    addr_list[0] = CFG_CURSOR_LEFT;   data_list[0] = 14'(left);
    addr_list[1] = CFG_CURSOR_TOP;    data_list[1] = 14'(top);
    addr_list[2] = CFG_CURSOR_WIDTH;  data_list[2] = 14'(cw);
    addr_list[3] = CFG_CURSOR_HEIGHT; data_list[3] = 14'(ch);
    addr_list[4] = CFG_REGION_WIDTH;  data_list[4] = 14'(rw);
    addr_list[5] = CFG_REGION_HEIGHT; data_list[5] = 14'(rh);
    addr_list[6] = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
    data_list[6] = 14'($urandom);
    for (k = 0; k < 7; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addr_list[k];
      cfg_wdata <= data_list[k];
      @(posedge clk);
      mirror_write(addr_list[k], data_list[k]);
      n_writes++;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small regions with the cursor near them; now and then the full range.
  task automatic random_config();
    int rw;
    int rh;
    int cw;
    int ch;
    int left;
    int top;
    rw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 400);
    rh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 400);
    cw = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
    ch = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
    left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 16383)) - 8192
                                       : int'($urandom_range(0, rw)) - 20;
    top  = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 16383)) - 8192
                                       : int'($urandom_range(0, rh)) - 20;
    configure(left, top, cw, ch, rw, rh);
  endtask

  // Traffic mix: most pixels land on or just around the cursor, some sit on
  // the region edge, the rest anywhere; loads scatter over the whole store.
  task automatic random_items(input int count);
    int k;
    int pick;
    int x;
    int y;
    int cwe;
    int che;
    int rwe;
    int rhe;
    cwe = (cur_w > MAX_CURSOR_SIDE) ? MAX_CURSOR_SIDE : int'(cur_w);
    che = (cur_h > MAX_CURSOR_SIDE) ? MAX_CURSOR_SIDE : int'(cur_h);
    rwe = (reg_w > MAX_REGION_SIDE) ? MAX_REGION_SIDE : int'(reg_w);
    rhe = (reg_h > MAX_REGION_SIDE) ? MAX_REGION_SIDE : int'(reg_h);
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_load($urandom_range(0, STORE_DEPTH - 1), rand_argb());
      end else begin
        if (pick < 70 && cwe > 0 && che > 0) begin
          x = cur_left + int'($urandom_range(0, cwe + 3)) - 2;
          y = cur_top + int'($urandom_range(0, che + 3)) - 2;
        end else if (pick < 80) begin
          x = rwe - 1 + int'($urandom_range(0, 1));
          y = rhe - 1 + int'($urandom_range(0, 1));
        end else begin
          x = $urandom_range(0, COORD_MAX);
          y = $urandom_range(0, COORD_MAX);
        end
        if (x < 0 || x > COORD_MAX) x = $urandom_range(0, COORD_MAX);
        if (y < 0 || y > COORD_MAX) y = $urandom_range(0, COORD_MAX);
        send_pixel(24'($urandom), x, y);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: out_ready with short random stalls, or one long hold-off on
  // request. Exactly one assignment to out_ready per edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0h expected %0h (result %0d)",
               $time, what, got, want, n_checked);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch(what, 32'(got), 32'(want));
  endtask

  // Each result transfer is matched against the oldest owed pixel.
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        report_mismatch("result with nothing pending",
                        {out_data.out_red, out_data.out_green,
                         out_data.out_blue, out_data.out_alpha}, '0);
      end else begin
        want = expected_px.pop_front();
        check_field("red", out_data.out_red, want.out_red);
        check_field("green", out_data.out_green, want.out_green);
        check_field("blue", out_data.out_blue, want.out_blue);
        check_field("alpha", out_data.out_alpha, want.out_alpha);
        check_field("out_of_region", 8'(out_data.out_of_region), 8'(want.out_of_region));
      end
      n_checked++;
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_count = 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results owed",
               $time, quiet_count, expected_px.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset: cursor size 0, region 4096 square, so every pixel
  // passes through. Corners of the coordinate range, black and white.
  task automatic test_reset_defaults();
    send_pixel(24'h000000, 0, 0);
    send_pixel(24'hFFFFFF, COORD_MAX, COORD_MAX);
    send_pixel(24'hA5A5A5, COORD_MAX, 0);
    send_pixel(24'h5A5A5A, 0, COORD_MAX);
    drain_results();
  endtask

  // Full-size cursor at the origin; the four store corners with opaque,
  // clear and partial alpha, a read right behind its load, and an overwrite.
  task automatic test_blend_corners();
    configure(0, 0, MAX_CURSOR_SIDE, MAX_CURSOR_SIDE, MAX_REGION_SIDE, MAX_REGION_SIDE);
    send_load(0, 32'hFFFFFFFF);
    send_load(63, 32'h00FFFFFF);
    send_load(4032, 32'h80FF0000);
    send_pixel(24'h000000, 0, 0);
    send_pixel(24'hFFFFFF, 63, 0);
    send_pixel(24'h00FF00, 0, 63);
    send_load(4095, 32'h7F00FF80);
    send_pixel(24'h123456, 63, 63);
    send_load(0, 32'h00000000);
    send_pixel(24'hFFFFFF, 0, 0);
    drain_results();
  endtask

  // Register extremes: zero region width, oversized cursor clamped to 64,
  // region edges, and oversized region clamped to 4096.
  task automatic test_region_and_size_limits();
    configure(-8192, 8191, 127, 127, 0, 8191);
    send_pixel(24'hABCDEF, 0, 0);
    send_pixel(24'h010203, COORD_MAX, COORD_MAX);
    drain_results();

    // cursor spans columns 0..61 (width clamps to 64 from left = -2)
    configure(-2, -3, 127, 127, 100, 50);
    send_pixel(24'h808080, 61, 0);
    send_pixel(24'h808080, 62, 0);
    send_pixel(24'h3C3C3C, 99, 49);
    send_pixel(24'hC3C3C3, 100, 0);
    send_pixel(24'hC3C3C3, 0, 50);
    drain_results();

    configure(4032, 4032, MAX_CURSOR_SIDE, MAX_CURSOR_SIDE, 8191, 8191);
    send_pixel(24'hFEDCBA, COORD_MAX, COORD_MAX);
    send_pixel(24'h102030, 4031, COORD_MAX);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      random_config();
      random_items(180);
      drain_results();
    end
  endtask

  // Long output stall while the sender keeps offering: the pipe fills and
  // in_ready must drop. The drain afterwards is the sender-side pause.
  task automatic test_output_stall();
    random_config();
    hold_req = 1'b1;
    random_items(60);
    drain_results();
  endtask

  // Closing stretch with no gaps on either side.
  task automatic test_back_to_back();
    random_config();
    idle_on = 1'b0;
    random_items(250);
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_blend_corners();
    test_region_and_size_limits();
    test_random_traffic();
    test_output_stall();
    test_back_to_back();

    $display("Run covered %0d pixel and %0d cursor load transfers, %0d register writes,",
             n_pixels, n_loads, n_writes);
    $display("%0d results compared, with random stalls, one long output hold-off and a gapless end.",
             n_checked);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
